// ----- src/llpo_pkg.sv -----
package llpo_pkg;

    localparam int NUM_PORTS  = 16;
    localparam int MAX_CAND   = 8;
    localparam int LOAD_W     = 16;
    localparam int PORT_W     = 4;
    localparam int CNT_W      = 4;
    localparam int POS_W      = 3;
    localparam int FUNC_W     = 2;
    localparam int NUM_FIELDS = 8;
    localparam int PIDX_W     = $clog2(NUM_PORTS);
    localparam int CIDX_W     = $clog2(MAX_CAND);

    localparam logic [FUNC_W-1:0] FUNC_ORDER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ISSUE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    typedef enum logic [1:0] {
        OP_ORDER,
        OP_ISSUE,
        OP_CLEAR
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE_RD,
        ST_ISSUE_WR,
        ST_LOAD_RD,
        ST_RANK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                              op;
        logic [PORT_W-1:0]                port;
        logic [CNT_W-1:0]                 count;
        logic [MAX_CAND-1:0][PORT_W-1:0]  cand;
    } cmd_t;

    function automatic logic tracked(input logic [PORT_W-1:0] p);
        return 32'(p) < NUM_PORTS;
    endfunction

endpackage

// ----- src/llpo_ram.sv -----
module llpo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/llpo_front.sv -----
module llpo_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [llpo_pkg::FUNC_W-1:0]   func,
    input  logic [llpo_pkg::PORT_W-1:0]   issued_port,
    input  logic [llpo_pkg::CNT_W-1:0]    cand_count,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_0,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_1,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_2,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_3,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_4,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_5,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_6,
    input  logic [llpo_pkg::PORT_W-1:0]   cand_port_7,
    output logic                          cmd_valid,
    output llpo_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    import llpo_pkg::*;

    logic [NUM_FIELDS-1:0][PORT_W-1:0] all_cand;
    cmd_t                              in_cmd;
    logic                              keep;
    logic                              push;
    cmd_t                              q_reg [2];
    logic                              wr_ptr_reg;
    logic                              wr_ptr_next;
    logic                              rd_ptr_reg;
    logic                              rd_ptr_next;
    logic [1:0]                        fill_reg;
    logic [1:0]                        fill_next;

    assign all_cand = {cand_port_7, cand_port_6, cand_port_5, cand_port_4,
                       cand_port_3, cand_port_2, cand_port_1, cand_port_0};

    // classify; drop unused codes and empty requests
    always_comb
    begin
        in_cmd.port  = issued_port;
        in_cmd.count = (32'(cand_count) > MAX_CAND) ? CNT_W'(MAX_CAND) : cand_count;
        for (int i = 0; i < MAX_CAND; i++)
        begin
            in_cmd.cand[i] = all_cand[i];
        end
        in_cmd.op = OP_ORDER;
        keep      = 1'b0;
        case (func)
            FUNC_ORDER:
            begin
                in_cmd.op = OP_ORDER;
                keep      = cand_count != '0;
            end
            FUNC_ISSUE:
            begin
                in_cmd.op = OP_ISSUE;
                keep      = 1'b1;
            end
            FUNC_CLEAR:
            begin
                in_cmd.op = OP_CLEAR;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready  = fill_reg != 2'd2;
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = fill_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, cmd_pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- src/llpo_back.sv -----
module llpo_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        greedy_mode,
    input  logic                        cmd_valid,
    input  llpo_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [llpo_pkg::PORT_W-1:0] ordered_port,
    output logic [llpo_pkg::POS_W-1:0]  position,
    output logic                        last_of_run
);

    import llpo_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    cmd_t                   cmd_reg;
    cmd_t                   cmd_next;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       idx_next;
    logic [LOAD_W-1:0]      load_reg [MAX_CAND];
    logic [LOAD_W-1:0]      load_next [MAX_CAND];
    logic [PORT_W-1:0]      sorted_reg [MAX_CAND];
    logic [PORT_W-1:0]      sorted_next [MAX_CAND];
    logic [NUM_PORTS-1:0]   ld_valid_reg;
    logic [NUM_PORTS-1:0]   ld_valid_next;
    logic                   rd_ok_reg;
    logic                   rd_ok_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PORT_W-1:0]      out_port_reg;
    logic [PORT_W-1:0]      out_port_next;
    logic [POS_W-1:0]       out_pos_reg;
    logic [POS_W-1:0]       out_pos_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic                   ram_we;
    logic [PIDX_W-1:0]      ram_waddr;
    logic [LOAD_W-1:0]      ram_wdata;
    logic [PIDX_W-1:0]      ram_raddr;
    logic [LOAD_W-1:0]      ram_rdata;

    logic [LOAD_W-1:0]      rd_load;
    logic                   out_free;
    logic                   last_idx;
    logic [CIDX_W-1:0]      cur;
    logic [PORT_W-1:0]      load_port;
    logic [PIDX_W-1:0]      load_addr;
    logic [CNT_W-1:0]       rank;

    llpo_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (NUM_PORTS)
    ) u_load_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_load   = rd_ok_reg ? ram_rdata : '0;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_idx  = idx_reg == (cmd_reg.count - CNT_W'(1));
    assign cur       = idx_reg[CIDX_W-1:0];
    assign load_port = cmd_reg.cand[cur];
    assign load_addr = PIDX_W'(load_port);

    // stable rank: lighter entries, or equal ones earlier in the list
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < MAX_CAND; j++)
        begin
            if (CNT_W'(j) < cmd_reg.count && CNT_W'(j) != idx_reg)
            begin
                if (load_reg[j] < load_reg[cur] ||
                    (load_reg[j] == load_reg[cur] && CNT_W'(j) < idx_reg))
                begin
                    rank = rank + CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_ISSUE:
                            state_next = tracked(cmd.port) ? ST_ISSUE_RD : ST_IDLE;
                        OP_ORDER:
                            state_next = (greedy_mode || cmd.count == CNT_W'(1)) ?
                                         ST_EMIT : ST_LOAD_RD;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ISSUE_RD:
                state_next = ST_ISSUE_WR;
            ST_ISSUE_WR:
                state_next = ST_IDLE;
            ST_LOAD_RD:
            begin
                if (idx_reg == cmd_reg.count)
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                if (last_idx)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && last_idx)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        load_next      = load_reg;
        sorted_next    = sorted_reg;
        ld_valid_next  = ld_valid_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_port_next  = out_port_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = PIDX_W'(cmd_reg.port);
        ram_raddr      = PIDX_W'(cmd_reg.port);
        ram_wdata      = (rd_load == LOAD_MAX) ? rd_load : rd_load + LOAD_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    idx_next = '0;
                    if (cmd.op == OP_CLEAR)
                    begin
                        ld_valid_next = '0;
                    end
                    if (cmd.op == OP_ORDER)
                    begin
                        for (int i = 0; i < MAX_CAND; i++)
                        begin
                            sorted_next[i] = cmd.cand[i];
                        end
                    end
                end
            end
            ST_ISSUE_RD:
            begin
                rd_ok_next = ld_valid_reg[PIDX_W'(cmd_reg.port)];
            end
            ST_ISSUE_WR:
            begin
                ram_we                   = 1'b1;
                ld_valid_next[ram_waddr] = 1'b1;
            end
            ST_LOAD_RD:
            begin
                ram_raddr  = load_addr;
                rd_ok_next = tracked(load_port) && ld_valid_reg[load_addr];
                if (idx_reg != '0)
                begin
                    load_next[CIDX_W'(idx_reg - CNT_W'(1))] = rd_load;
                end
                idx_next = (idx_reg == cmd_reg.count) ? '0 : idx_reg + CNT_W'(1);
            end
            ST_RANK:
            begin
                sorted_next[rank[CIDX_W-1:0]] = cmd_reg.cand[cur];
                idx_next = last_idx ? '0 : idx_reg + CNT_W'(1);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_port_next  = sorted_reg[cur];
                    out_pos_next   = POS_W'(idx_reg);
                    out_last_next  = last_idx;
                    idx_next       = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            ld_valid_reg  <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ld_valid_reg  <= ld_valid_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        load_reg     <= load_next;
        sorted_reg   <= sorted_next;
        out_port_reg <= out_port_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign ordered_port = out_port_reg;
    assign position     = out_pos_reg;
    assign last_of_run  = out_last_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE && cmd_valid))
        else $error("command popped outside idle");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.op == OP_CLEAR) |=> (ld_valid_reg == '0))
        else $error("clear left a load valid");

    a_load_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD_RD) |-> (idx_reg <= cmd_reg.count))
        else $error("load read index past candidate count");

    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && last_idx) |=>
            (out_valid_reg && out_last_reg && state_reg == ST_IDLE))
        else $error("final item of an ordering not marked");

endmodule

// ----- src/least_loaded_port_orderer_core.sv -----
// Issue: a load read, then a write-back; clear: at pop; items queue two deep ahead
// of the back end. Order of n candidates, greedy or n of 1: n results, one per cycle
// while out_ready allows. Sorted by load: a load read per candidate, then n rank
// steps, then n results likewise; the load memory has a single read port.
// Reset clears every load through its valid bit at once and sets greedy_mode to 0.
module least_loaded_port_orderer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [llpo_pkg::FUNC_W-1:0] func,
    input  logic [llpo_pkg::PORT_W-1:0] issued_port,
    input  logic [llpo_pkg::CNT_W-1:0]  cand_count,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_0,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_1,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_2,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_3,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_4,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_5,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_6,
    input  logic [llpo_pkg::PORT_W-1:0] cand_port_7,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [llpo_pkg::PORT_W-1:0] ordered_port,
    output logic [llpo_pkg::POS_W-1:0]  position,
    output logic                        last_of_run
);

    import llpo_pkg::*;

    logic greedy_mode_reg;
    logic greedy_mode_next;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    assign greedy_mode_next = cfg_we ? cfg_wdata : greedy_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greedy_mode_reg <= 1'b0;
        end
        else
        begin
            greedy_mode_reg <= greedy_mode_next;
        end
    end

    llpo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .issued_port (issued_port),
        .cand_count  (cand_count),
        .cand_port_0 (cand_port_0),
        .cand_port_1 (cand_port_1),
        .cand_port_2 (cand_port_2),
        .cand_port_3 (cand_port_3),
        .cand_port_4 (cand_port_4),
        .cand_port_5 (cand_port_5),
        .cand_port_6 (cand_port_6),
        .cand_port_7 (cand_port_7),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    llpo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .greedy_mode  (greedy_mode_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ordered_port (ordered_port),
        .position     (position),
        .last_of_run  (last_of_run)
    );

endmodule
